// ===== rtl/sspd_pkg.sv =====
// ----------------------------------------------------------------------------
// sspd_pkg
// shared widths, register indexes and reset values for the skid-steer drive
// ----------------------------------------------------------------------------
package sspd_pkg;

   // field widths
   localparam int IN_W      = 16;
   localparam int CFG_W     = 16;
   localparam int LIM_W     = 15;
   localparam int ERR_W     = 24;
   localparam int SUM_W     = IN_W + 1;
   localparam int CSR_IDX_W = 3;

   // defaults of the top level parameters
   localparam int FRAC_BITS_DEF = 8;
   localparam int REF_CLAMP_DEF = 2560;

   // serial unit defaults, as they follow from the default fraction width
   localparam int MUL_A_W_DEF = ERR_W + 2 + CFG_W - FRAC_BITS_DEF;
   localparam int DIV_N_W_DEF = 2 * IN_W - 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WHEEL_DIAMETER = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TRACK_WIDTH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P_LINEAR  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D_LINEAR  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P_ANGULAR = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D_ANGULAR = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DRIVE_LIMIT    = 3'd6;

   // register reset values
   localparam logic [CFG_W-1:0] WHEEL_DIAMETER_RST = 16'd64;
   localparam logic [CFG_W-1:0] TRACK_WIDTH_RST    = 16'd256;
   localparam logic [CFG_W-1:0] GAIN_P_LINEAR_RST  = 16'd640;
   localparam logic [CFG_W-1:0] GAIN_D_LINEAR_RST  = 16'd0;
   localparam logic [CFG_W-1:0] GAIN_P_ANGULAR_RST = 16'd6400;
   localparam logic [CFG_W-1:0] GAIN_D_ANGULAR_RST = 16'd3840;
   localparam logic [LIM_W-1:0] DRIVE_LIMIT_RST    = 15'd25600;

endpackage

// ===== rtl/sspd_mul.sv =====
// ----------------------------------------------------------------------------
// sspd_mul
// bit-serial signed by unsigned multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module sspd_mul import sspd_pkg::*; #(
   parameter int A_W = MUL_A_W_DEF,
   parameter int B_W = CFG_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [A_W-1:0]    a,
   input  logic        [B_W-1:0]    b,
   output logic                     done,
   output logic signed [A_W+B_W-1:0] product
);

   localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

   logic signed [A_W-1:0] a_ff, a_in;
   logic        [B_W-1:0] b_ff, b_in;
   logic signed [A_W:0]   hi_ff, hi_in;
   logic        [B_W-1:0] lo_ff, lo_in;
   logic        [CNT_W-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic signed [A_W:0]   addend;
   logic signed [A_W:0]   step_sum;

   assign addend   = b_ff[0] ? (A_W+1)'(a_ff) : '0;
   assign step_sum = hi_ff + addend;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         a_in    = a;
         b_in    = b;
         hi_in   = '0;
         lo_in   = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // add, then shift the partial product one place right
         hi_in  = step_sum >>> 1;
         lo_in  = {step_sum[0], lo_ff[B_W-1:1]};
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff  <= a_in;
      b_ff  <= b_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign done    = done_ff;
   assign product = $signed({hi_ff[A_W-1:0], lo_ff});

endmodule

// ===== rtl/sspd_div.sv =====
// ----------------------------------------------------------------------------
// sspd_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sspd_div import sspd_pkg::*; #(
   parameter int N_W = DIV_N_W_DEF,
   parameter int D_W = CFG_W
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] num,
   input  logic [D_W-1:0] den,
   output logic           done,
   output logic [N_W-1:0] quotient
);

   localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;

   logic [N_W-1:0]   quo_ff, quo_in;
   logic [D_W-1:0]   rem_ff, rem_in;
   logic [D_W-1:0]   den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [D_W:0]     rem_shift;
   logic [D_W:0]     rem_sub;
   logic             fits;

   assign rem_shift = {rem_ff, quo_ff[N_W-1]};
   assign rem_sub   = rem_shift - {1'b0, den_ff};
   assign fits      = (rem_shift >= {1'b0, den_ff});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sub[D_W-1:0] : rem_shift[D_W-1:0];
         quo_in = {quo_ff[N_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/skid_steer_pd_wheel_drive.sv =====
// ----------------------------------------------------------------------------
// skid_steer_pd_wheel_drive
// pd velocity controller for a four-wheel skid-steer base, serial datapath
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  four wheel speeds, two references
//  rsp      out        rsp_valid/rsp_stall  left/right drive, speeds, clamped
//  csr      in         csr_valid/csr_ready  csr_index, csr_data
//
//  a beat runs from acceptance to the next acceptance through seven
//  products on the shared bit-serial multiplier (one bit of the 16-bit
//  operand per cycle) and the 31-step restoring divider for the angular
//  speed, plus the prepare, error and output steps
//  reset is synchronous; it restores the registers to their defaults and
//  clears the stored errors and both handshakes
//  a result waiting under rsp_stall does not hold up the next req beat; only
//  loading the following result waits for the output register to empty
//  csr_ready is always high
//
module skid_steer_pd_wheel_drive import sspd_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int REF_CLAMP = REF_CLAMP_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [IN_W-1:0]  req_vel_front_left,
   input  logic signed [IN_W-1:0]  req_vel_front_right,
   input  logic signed [IN_W-1:0]  req_vel_back_left,
   input  logic signed [IN_W-1:0]  req_vel_back_right,
   input  logic signed [IN_W-1:0]  req_ref_linear,
   input  logic signed [IN_W-1:0]  req_ref_angular,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [IN_W-1:0]  rsp_drive_left,
   output logic signed [IN_W-1:0]  rsp_drive_right,
   output logic signed [IN_W-1:0]  rsp_speed_linear,
   output logic signed [IN_W-1:0]  rsp_speed_angular,
   output logic                    rsp_clamped,
   // register write port
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CFG_W-1:0]        csr_data
);

   // widths that follow from the fraction width
   localparam int VEL_W   = SUM_W + CFG_W - FRAC_BITS - 2;     // side speeds, linear speed
   localparam int DIFF_W  = VEL_W + 1;                         // side speed sum or difference
   localparam int ANG_W   = DIFF_W + FRAC_BITS;                // angular speed
   localparam int DIV_W   = ANG_W - 1;                         // divider magnitude
   localparam int DE_W    = ERR_W + 1;                         // error change
   localparam int MA_W    = DE_W + CFG_W + 1 - FRAC_BITS;      // multiplicand, pd outputs
   localparam int P_W     = MA_W + CFG_W;                      // products
   localparam int SHIFT_W = MA_W + FRAC_BITS + 1;              // scaled linear command
   localparam int LR_W    = ((SHIFT_W > P_W) ? SHIFT_W : P_W) + 1;
   localparam int SAT_W   = ANG_W + 2;

   localparam logic signed [IN_W-1:0]  REF_HI = IN_W'(REF_CLAMP);
   localparam logic signed [IN_W-1:0]  REF_LO = -REF_HI;
   localparam logic signed [SAT_W-1:0] ERR_HI = SAT_W'((1 << (ERR_W - 1)) - 1);
   localparam logic signed [SAT_W-1:0] ERR_LO = ~ERR_HI;
   localparam logic signed [SAT_W-1:0] OUT_HI = SAT_W'((1 << (IN_W - 1)) - 1);
   localparam logic signed [SAT_W-1:0] OUT_LO = ~OUT_HI;

   // sequencer states
   localparam int STATE_W = 3;
   localparam logic [STATE_W-1:0] S_IDLE = 3'd0;
   localparam logic [STATE_W-1:0] S_MUL  = 3'd1;
   localparam logic [STATE_W-1:0] S_PREP = 3'd2;
   localparam logic [STATE_W-1:0] S_DIV  = 3'd3;
   localparam logic [STATE_W-1:0] S_ERR  = 3'd4;
   localparam logic [STATE_W-1:0] S_OUT  = 3'd5;

   // products, in the order they are formed
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_VL = 3'd0;   // left wheel sum times diameter
   localparam logic [OP_W-1:0] OP_VR = 3'd1;   // right wheel sum times diameter
   localparam logic [OP_W-1:0] OP_PL = 3'd2;   // linear proportional
   localparam logic [OP_W-1:0] OP_DL = 3'd3;   // linear derivative
   localparam logic [OP_W-1:0] OP_PA = 3'd4;   // angular proportional
   localparam logic [OP_W-1:0] OP_DA = 3'd5;   // angular derivative
   localparam logic [OP_W-1:0] OP_WT = 3'd6;   // track width times angular command

   function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [SAT_W-1:0] x);
      logic signed [SAT_W-1:0] y;
      y = x;
      if (x > ERR_HI) y = ERR_HI;
      else if (x < ERR_LO) y = ERR_LO;
      return ERR_W'(y);
   endfunction

   function automatic logic signed [IN_W-1:0] sat_out(input logic signed [SAT_W-1:0] x);
      logic signed [SAT_W-1:0] y;
      y = x;
      if (x > OUT_HI) y = OUT_HI;
      else if (x < OUT_LO) y = OUT_LO;
      return IN_W'(y);
   endfunction

   // configuration registers
   logic [CFG_W-1:0] wheel_diameter_ff, wheel_diameter_in;
   logic [CFG_W-1:0] track_width_ff, track_width_in;
   logic [CFG_W-1:0] gain_p_linear_ff, gain_p_linear_in;
   logic [CFG_W-1:0] gain_d_linear_ff, gain_d_linear_in;
   logic [CFG_W-1:0] gain_p_angular_ff, gain_p_angular_in;
   logic [CFG_W-1:0] gain_d_angular_ff, gain_d_angular_in;
   logic [LIM_W-1:0] drive_limit_ff, drive_limit_in;

   // control
   logic [STATE_W-1:0] state_ff, state_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic               kick_ff, kick_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // stored errors of the previous tick
   logic signed [ERR_W-1:0] prev_err_lin_ff, prev_err_lin_in;
   logic signed [ERR_W-1:0] prev_err_ang_ff, prev_err_ang_in;

   // working registers
   logic signed [SUM_W-1:0] sum_l_ff, sum_l_in;
   logic signed [SUM_W-1:0] sum_r_ff, sum_r_in;
   logic signed [IN_W-1:0]  ref_lin_ff, ref_lin_in;
   logic signed [IN_W-1:0]  ref_ang_ff, ref_ang_in;
   logic signed [VEL_W-1:0] vel_l_ff, vel_l_in;
   logic signed [VEL_W-1:0] vel_r_ff, vel_r_in;
   logic signed [VEL_W-1:0] lin_ff, lin_in;
   logic signed [ANG_W-1:0] ang_ff, ang_in;
   logic        [DIV_W-1:0] div_num_ff, div_num_in;
   logic                    div_neg_ff, div_neg_in;
   logic signed [ERR_W-1:0] err_lin_ff, err_lin_in;
   logic signed [ERR_W-1:0] err_ang_ff, err_ang_in;
   logic signed [P_W-1:0]   acc_ff, acc_in;
   logic signed [MA_W-1:0]  uv_ff, uv_in;
   logic signed [MA_W-1:0]  uw_ff, uw_in;

   // output register
   logic signed [IN_W-1:0]  drive_left_ff, drive_left_in;
   logic signed [IN_W-1:0]  drive_right_ff, drive_right_in;
   logic signed [IN_W-1:0]  speed_lin_ff, speed_lin_in;
   logic signed [IN_W-1:0]  speed_ang_ff, speed_ang_in;
   logic                    clamped_ff, clamped_in;

   // datapath nets
   logic                    req_accept;
   logic                    csr_write;
   logic [CFG_W-1:0]        track_eff;
   logic signed [SUM_W-1:0] wheels_l, wheels_r;
   logic signed [IN_W-1:0]  ref_lin_sat, ref_ang_sat;
   logic signed [DIFF_W-1:0] vel_sum, vel_diff;
   logic        [ANG_W-1:0] ang_num;
   logic        [ANG_W-1:0] ang_mag;
   logic        [ANG_W-1:0] quo_ext;
   logic signed [SAT_W-1:0] err_lin_wide, err_ang_wide;
   logic signed [DE_W-1:0]  de_lin, de_ang;
   logic signed [P_W-1:0]   pd_sum;
   logic signed [LR_W-1:0]  uv_scaled, w_term;
   logic signed [LR_W-1:0]  left_pre, right_pre, left_full, right_full;
   logic signed [LR_W-1:0]  lim_pos, lim_neg;
   logic signed [LR_W-1:0]  left_sat, right_sat;
   logic                    limit_hit;
   logic                    out_load;

   // serial units
   logic                    mul_start, mul_done;
   logic signed [MA_W-1:0]  mul_a;
   logic        [CFG_W-1:0] mul_b;
   logic signed [P_W-1:0]   mul_prod;
   logic                    div_start, div_done;
   logic        [DIV_W-1:0] div_quo;

   assign req_accept = req_valid && !req_stall;
   assign csr_write  = csr_valid && csr_ready;
   assign track_eff  = (track_width_ff == '0) ? CFG_W'(1) : track_width_ff;

   // reference clamp and wheel sums at the input
   assign wheels_l = SUM_W'(req_vel_front_left) + SUM_W'(req_vel_back_left);
   assign wheels_r = SUM_W'(req_vel_front_right) + SUM_W'(req_vel_back_right);
   assign ref_lin_sat = (req_ref_linear > REF_HI) ? REF_HI :
                        (req_ref_linear < REF_LO) ? REF_LO : req_ref_linear;
   assign ref_ang_sat = (req_ref_angular > REF_HI) ? REF_HI :
                        (req_ref_angular < REF_LO) ? REF_LO : req_ref_angular;

   // side speed sum and difference
   assign vel_sum  = DIFF_W'(vel_r_ff) + DIFF_W'(vel_l_ff);
   assign vel_diff = DIFF_W'(vel_r_ff) - DIFF_W'(vel_l_ff);

   // floor division of a negative value goes through its complement
   assign ang_num = {vel_diff, {FRAC_BITS{1'b0}}};
   assign ang_mag = vel_diff[DIFF_W-1] ? ~ang_num : ang_num;
   assign quo_ext = {1'b0, div_quo};

   // errors before saturation
   assign err_lin_wide = SAT_W'(ref_lin_ff) - SAT_W'(lin_ff);
   assign err_ang_wide = SAT_W'(ref_ang_ff) - SAT_W'(ang_ff);
   assign de_lin = DE_W'(err_lin_ff) - DE_W'(prev_err_lin_ff);
   assign de_ang = DE_W'(err_ang_ff) - DE_W'(prev_err_ang_ff);
   assign pd_sum = acc_ff + mul_prod;

   // inverse kinematics, halving folded into the final shift
   assign uv_scaled  = LR_W'(uv_ff) <<< (FRAC_BITS + 1);
   assign w_term     = LR_W'(acc_ff);
   assign left_pre   = uv_scaled - w_term;
   assign right_pre  = uv_scaled + w_term;
   assign left_full  = left_pre >>> (FRAC_BITS + 2);
   assign right_full = right_pre >>> (FRAC_BITS + 2);
   assign lim_pos    = $signed(LR_W'(drive_limit_ff));
   assign lim_neg    = -lim_pos;
   assign left_sat   = (left_full > lim_pos) ? lim_pos :
                       (left_full < lim_neg) ? lim_neg : left_full;
   assign right_sat  = (right_full > lim_pos) ? lim_pos :
                       (right_full < lim_neg) ? lim_neg : right_full;
   // a drive exactly on the limit does not count as clamped
   assign limit_hit  = (left_full > lim_pos) || (left_full < lim_neg) ||
                       (right_full > lim_pos) || (right_full < lim_neg);

   // the output register takes a result once it is empty or being emptied
   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (op_ff)
         OP_VL: begin
            mul_a = MA_W'(sum_l_ff);
            mul_b = wheel_diameter_ff;
         end
         OP_VR: begin
            mul_a = MA_W'(sum_r_ff);
            mul_b = wheel_diameter_ff;
         end
         OP_PL: begin
            mul_a = MA_W'(err_lin_ff);
            mul_b = gain_p_linear_ff;
         end
         OP_DL: begin
            mul_a = MA_W'(de_lin);
            mul_b = gain_d_linear_ff;
         end
         OP_PA: begin
            mul_a = MA_W'(err_ang_ff);
            mul_b = gain_p_angular_ff;
         end
         OP_DA: begin
            mul_a = MA_W'(de_ang);
            mul_b = gain_d_angular_ff;
         end
         OP_WT: begin
            mul_a = uw_ff;
            mul_b = track_eff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_start = kick_ff && (state_ff == S_MUL);
   assign div_start = kick_ff && (state_ff == S_DIV);

   // register writes
   always_comb begin
      wheel_diameter_in = wheel_diameter_ff;
      track_width_in    = track_width_ff;
      gain_p_linear_in  = gain_p_linear_ff;
      gain_d_linear_in  = gain_d_linear_ff;
      gain_p_angular_in = gain_p_angular_ff;
      gain_d_angular_in = gain_d_angular_ff;
      drive_limit_in    = drive_limit_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_WHEEL_DIAMETER: wheel_diameter_in = csr_data;
            REG_TRACK_WIDTH:    track_width_in    = csr_data;
            REG_GAIN_P_LINEAR:  gain_p_linear_in  = csr_data;
            REG_GAIN_D_LINEAR:  gain_d_linear_in  = csr_data;
            REG_GAIN_P_ANGULAR: gain_p_angular_in = csr_data;
            REG_GAIN_D_ANGULAR: gain_d_angular_in = csr_data;
            REG_DRIVE_LIMIT:    drive_limit_in    = csr_data[LIM_W-1:0];
            default: ;  // index beyond the register list, write dropped
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      kick_in         = 1'b0;
      prev_err_lin_in = prev_err_lin_ff;
      prev_err_ang_in = prev_err_ang_ff;
      sum_l_in        = sum_l_ff;
      sum_r_in        = sum_r_ff;
      ref_lin_in      = ref_lin_ff;
      ref_ang_in      = ref_ang_ff;
      vel_l_in        = vel_l_ff;
      vel_r_in        = vel_r_ff;
      lin_in          = lin_ff;
      ang_in          = ang_ff;
      div_num_in      = div_num_ff;
      div_neg_in      = div_neg_ff;
      err_lin_in      = err_lin_ff;
      err_ang_in      = err_ang_ff;
      acc_in          = acc_ff;
      uv_in           = uv_ff;
      uw_in           = uw_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               sum_l_in   = wheels_l;
               sum_r_in   = wheels_r;
               ref_lin_in = ref_lin_sat;
               ref_ang_in = ref_ang_sat;
               op_in      = OP_VL;
               kick_in    = 1'b1;
               state_in   = S_MUL;
            end
         end
         S_MUL: begin
            if (mul_done) begin
               case (op_ff)
                  OP_VL: begin
                     // mean of two wheels times half the diameter
                     vel_l_in = VEL_W'(mul_prod >>> (FRAC_BITS + 2));
                     op_in    = OP_VR;
                     kick_in  = 1'b1;
                  end
                  OP_VR: begin
                     vel_r_in = VEL_W'(mul_prod >>> (FRAC_BITS + 2));
                     state_in = S_PREP;
                  end
                  OP_PL: begin
                     acc_in  = mul_prod;
                     op_in   = OP_DL;
                     kick_in = 1'b1;
                  end
                  OP_DL: begin
                     uv_in           = MA_W'(pd_sum >>> FRAC_BITS);
                     prev_err_lin_in = err_lin_ff;
                     op_in           = OP_PA;
                     kick_in         = 1'b1;
                  end
                  OP_PA: begin
                     acc_in  = mul_prod;
                     op_in   = OP_DA;
                     kick_in = 1'b1;
                  end
                  OP_DA: begin
                     uw_in           = MA_W'(pd_sum >>> FRAC_BITS);
                     prev_err_ang_in = err_ang_ff;
                     op_in           = OP_WT;
                     kick_in         = 1'b1;
                  end
                  default: begin
                     // track width term, kept in the accumulator
                     acc_in   = mul_prod;
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_PREP: begin
            lin_in     = VEL_W'(vel_sum >>> 1);
            div_num_in = ang_mag[DIV_W-1:0];
            div_neg_in = vel_diff[DIFF_W-1];
            kick_in    = 1'b1;
            state_in   = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               ang_in   = $signed(div_neg_ff ? ~quo_ext : quo_ext);
               state_in = S_ERR;
            end
         end
         S_ERR: begin
            err_lin_in = sat_err(err_lin_wide);
            err_ang_in = sat_err(err_ang_wide);
            op_in      = OP_PL;
            kick_in    = 1'b1;
            state_in   = S_MUL;
         end
         S_OUT: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      drive_left_in  = drive_left_ff;
      drive_right_in = drive_right_ff;
      speed_lin_in   = speed_lin_ff;
      speed_ang_in   = speed_ang_ff;
      clamped_in     = clamped_ff;
      rsp_valid_in   = rsp_valid_ff;
      if (out_load) begin
         drive_left_in  = IN_W'(left_sat);
         drive_right_in = IN_W'(right_sat);
         speed_lin_in   = sat_out(SAT_W'(lin_ff));
         speed_ang_in   = sat_out(SAT_W'(ang_ff));
         clamped_in     = limit_hit;
         rsp_valid_in   = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_diameter_ff <= WHEEL_DIAMETER_RST;
         track_width_ff    <= TRACK_WIDTH_RST;
         gain_p_linear_ff  <= GAIN_P_LINEAR_RST;
         gain_d_linear_ff  <= GAIN_D_LINEAR_RST;
         gain_p_angular_ff <= GAIN_P_ANGULAR_RST;
         gain_d_angular_ff <= GAIN_D_ANGULAR_RST;
         drive_limit_ff    <= DRIVE_LIMIT_RST;
         state_ff          <= S_IDLE;
         op_ff             <= OP_VL;
         kick_ff           <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         prev_err_lin_ff   <= '0;
         prev_err_ang_ff   <= '0;
      end else begin
         wheel_diameter_ff <= wheel_diameter_in;
         track_width_ff    <= track_width_in;
         gain_p_linear_ff  <= gain_p_linear_in;
         gain_d_linear_ff  <= gain_d_linear_in;
         gain_p_angular_ff <= gain_p_angular_in;
         gain_d_angular_ff <= gain_d_angular_in;
         drive_limit_ff    <= drive_limit_in;
         state_ff          <= state_in;
         op_ff             <= op_in;
         kick_ff           <= kick_in;
         rsp_valid_ff      <= rsp_valid_in;
         prev_err_lin_ff   <= prev_err_lin_in;
         prev_err_ang_ff   <= prev_err_ang_in;
      end
      sum_l_ff       <= sum_l_in;
      sum_r_ff       <= sum_r_in;
      ref_lin_ff     <= ref_lin_in;
      ref_ang_ff     <= ref_ang_in;
      vel_l_ff       <= vel_l_in;
      vel_r_ff       <= vel_r_in;
      lin_ff         <= lin_in;
      ang_ff         <= ang_in;
      div_num_ff     <= div_num_in;
      div_neg_ff     <= div_neg_in;
      err_lin_ff     <= err_lin_in;
      err_ang_ff     <= err_ang_in;
      acc_ff         <= acc_in;
      uv_ff          <= uv_in;
      uw_ff          <= uw_in;
      drive_left_ff  <= drive_left_in;
      drive_right_ff <= drive_right_in;
      speed_lin_ff   <= speed_lin_in;
      speed_ang_ff   <= speed_ang_in;
      clamped_ff     <= clamped_in;
   end

   // shared bit-serial multiplier
   sspd_mul #(
      .A_W (MA_W),
      .B_W (CFG_W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   // angular speed divider
   sspd_div #(
      .N_W (DIV_W),
      .D_W (CFG_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num_ff),
      .den      (track_eff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive_left    = drive_left_ff;
   assign rsp_drive_right   = drive_right_ff;
   assign rsp_speed_linear  = speed_lin_ff;
   assign rsp_speed_angular = speed_ang_ff;
   assign rsp_clamped       = clamped_ff;
   assign csr_ready         = 1'b1;

endmodule

// ===== rtl/sspd_checker.sv =====
// ----------------------------------------------------------------------------
// sspd_checker
// port-level checks on the skid-steer drive, bound to the top level
// ----------------------------------------------------------------------------
module sspd_checker import sspd_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic signed [IN_W-1:0] rsp_drive_left,
   input logic signed [IN_W-1:0] rsp_drive_right
);

   // idle and empty straight after a reset cycle
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

   // one beat at a time: busy once a beat is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second beat could be taken while busy");

   // a result only comes out of work in progress
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a beat in progress");

   // a stalled result holds
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive_left)
                                 && $stable(rsp_drive_right))
      else $error("stalled result changed");

   // drives stay within the symmetric range a 15-bit limit allows, never -32768
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive_left != 16'sh8000) && (rsp_drive_right != 16'sh8000))
      else $error("drive outside symmetric range");

endmodule

bind skid_steer_pd_wheel_drive sspd_checker u_sspd_checker (.*);

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the skid-steer pd wheel drive: a scoreboard class
// predicts every result beat from the accepted request beats and the current
// register settings, while plain tasks drive the request and register ports
// and a free-running process stalls the result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import sspd_pkg::*;

   localparam int     FRAC            = FRAC_BITS_DEF;
   localparam longint ERR_HI          = 64'sd8388607;
   localparam longint ERR_LO          = -64'sd8388608;
   // watchdog bound for ~1375 beats plus stalls and hold-offs
   localparam int     LIMIT_CYCLES    = 3000000;
   localparam int     HOLD_CYCLES     = 2000;
   // settle time, enough to flush out any stray result
   localparam int     SETTLE_CYCLES   = 400;
   localparam int     RANDOM_PHASES   = 8;
   localparam int     ITEMS_PER_PHASE = 170;
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 3'd7;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [IN_W-1:0] vel_front_left;
      logic [IN_W-1:0] vel_front_right;
      logic [IN_W-1:0] vel_back_left;
      logic [IN_W-1:0] vel_back_right;
      logic [IN_W-1:0] ref_linear;
      logic [IN_W-1:0] ref_angular;
   } wheel_req_type;

   typedef struct packed {
      logic [IN_W-1:0] drive_left;
      logic [IN_W-1:0] drive_right;
      logic [IN_W-1:0] speed_linear;
      logic [IN_W-1:0] speed_angular;
      logic            clamped;
   } drive_rsp_type;

   // -------------------------------------------------------------------------
   // scoreboard: register shadow, stored errors and the queue of drive results
   // -------------------------------------------------------------------------
   class drive_scoreboard;
      longint        wheel_diameter, track_width, drive_limit;
      longint        gain_p_lin, gain_d_lin, gain_p_ang, gain_d_ang;
      longint        last_err_lin, last_err_ang;
      drive_rsp_type pending_drives[$];
      int            mismatches;

      function new();
         wheel_diameter = longint'(WHEEL_DIAMETER_RST);
         track_width    = longint'(TRACK_WIDTH_RST);
         gain_p_lin     = longint'(GAIN_P_LINEAR_RST);
         gain_d_lin     = longint'(GAIN_D_LINEAR_RST);
         gain_p_ang     = longint'(GAIN_P_ANGULAR_RST);
         gain_d_ang     = longint'(GAIN_D_ANGULAR_RST);
         drive_limit    = longint'(DRIVE_LIMIT_RST);
         last_err_lin   = 0;
         last_err_ang   = 0;
         mismatches     = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
         case (idx)
            REG_WHEEL_DIAMETER: wheel_diameter = longint'(data);
            REG_TRACK_WIDTH:    track_width    = longint'(data);
            REG_GAIN_P_LINEAR:  gain_p_lin     = longint'(data);
            REG_GAIN_D_LINEAR:  gain_d_lin     = longint'(data);
            REG_GAIN_P_ANGULAR: gain_p_ang     = longint'(data);
            REG_GAIN_D_ANGULAR: gain_d_ang     = longint'(data);
            REG_DRIVE_LIMIT:    drive_limit    = longint'(data[LIM_W-1:0]);
            default: ;
         endcase
      endfunction

      function longint sx(logic [IN_W-1:0] v);
         return longint'($signed(v));
      endfunction

      function longint sat(longint x, longint lo, longint hi);
         if (x > hi) return hi;
         if (x < lo) return lo;
         return x;
      endfunction

      // division rounding toward minus infinity, d > 0
      function longint floor_div(longint x, longint d);
         longint q;
         q = x / d;
         if ((x % d != 0) && (x < 0)) q = q - 1;
         return q;
      endfunction

      function drive_rsp_type predict_drive(wheel_req_type r);
         longint        rv, rw, t, vl, vr, lin, ang, ev, ew, uv, uw, left, right;
         drive_rsp_type res;
         rv = sat(sx(r.ref_linear), -REF_CLAMP_DEF, REF_CLAMP_DEF);
         rw = sat(sx(r.ref_angular), -REF_CLAMP_DEF, REF_CLAMP_DEF);
         t  = (track_width == 0) ? 1 : track_width;
         // side speed: wheel mean times half diameter, so divide by four
         vl = ((sx(r.vel_front_left) + sx(r.vel_back_left)) * wheel_diameter)
              >>> (FRAC + 2);
         vr = ((sx(r.vel_front_right) + sx(r.vel_back_right)) * wheel_diameter)
              >>> (FRAC + 2);
         lin = (vr + vl) >>> 1;
         ang = floor_div((vr - vl) <<< FRAC, t);
         ev  = sat(rv - lin, ERR_LO, ERR_HI);
         ew  = sat(rw - ang, ERR_LO, ERR_HI);
         uv  = (gain_p_lin * ev + gain_d_lin * (ev - last_err_lin)) >>> FRAC;
         uw  = (gain_p_ang * ew + gain_d_ang * (ew - last_err_ang)) >>> FRAC;
         last_err_lin = ev;
         last_err_ang = ew;
         left  = ((uv <<< (FRAC + 1)) - t * uw) >>> (FRAC + 2);
         right = ((uv <<< (FRAC + 1)) + t * uw) >>> (FRAC + 2);
         res.clamped = (left > drive_limit) || (left < -drive_limit) ||
                       (right > drive_limit) || (right < -drive_limit);
         res.drive_left    = IN_W'(sat(left, -drive_limit, drive_limit));
         res.drive_right   = IN_W'(sat(right, -drive_limit, drive_limit));
         res.speed_linear  = IN_W'(sat(lin, -32768, 32767));
         res.speed_angular = IN_W'(sat(ang, -32768, 32767));
         return res;
      endfunction

      function void note_request(wheel_req_type r);
         pending_drives.push_back(predict_drive(r));
      endfunction

      function void check_response(drive_rsp_type got);
         drive_rsp_type want;
         if (pending_drives.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: L %0d R %0d v %0d w %0d c %0b",
                        $signed(got.drive_left), $signed(got.drive_right),
                        $signed(got.speed_linear), $signed(got.speed_angular),
                        got.clamped);
            return;
         end
         want = pending_drives.pop_front();
         if (got.drive_left !== want.drive_left || got.drive_right !== want.drive_right ||
             got.speed_linear !== want.speed_linear ||
             got.speed_angular !== want.speed_angular || got.clamped !== want.clamped) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result mismatch, expected L %0d R %0d v %0d w %0d c %0b",
                        $signed(want.drive_left), $signed(want.drive_right),
                        $signed(want.speed_linear), $signed(want.speed_angular),
                        want.clamped);
               $display("                 actual   L %0d R %0d v %0d w %0d c %0b",
                        $signed(got.drive_left), $signed(got.drive_right),
                        $signed(got.speed_linear), $signed(got.speed_angular),
                        got.clamped);
            end
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // clock, reset and block ports, the driven ones known from time zero
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [IN_W-1:0]      req_vel_front_left  = '0;
   logic [IN_W-1:0]      req_vel_front_right = '0;
   logic [IN_W-1:0]      req_vel_back_left   = '0;
   logic [IN_W-1:0]      req_vel_back_right  = '0;
   logic [IN_W-1:0]      req_ref_linear      = '0;
   logic [IN_W-1:0]      req_ref_angular     = '0;

   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [IN_W-1:0]      rsp_drive_left;
   logic [IN_W-1:0]      rsp_drive_right;
   logic [IN_W-1:0]      rsp_speed_linear;
   logic [IN_W-1:0]      rsp_speed_angular;
   logic                 rsp_clamped;

   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_data  = '0;

   // idling knobs, set per phase by the stimulus sequence
   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;
   int hold_requests   = 0;
   int hold_seen       = 0;
   int hold_left       = 0;
   int cycle_count     = 0;

   drive_scoreboard sb = new();

   always #2 clock = ~clock;

   skid_steer_pd_wheel_drive i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_vel_front_left  (req_vel_front_left),
      .req_vel_front_right (req_vel_front_right),
      .req_vel_back_left   (req_vel_back_left),
      .req_vel_back_right  (req_vel_back_right),
      .req_ref_linear      (req_ref_linear),
      .req_ref_angular     (req_ref_angular),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_drive_left      (rsp_drive_left),
      .rsp_drive_right     (rsp_drive_right),
      .rsp_speed_linear    (rsp_speed_linear),
      .rsp_speed_angular   (rsp_speed_angular),
      .rsp_clamped         (rsp_clamped),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   // -------------------------------------------------------------------------
   // monitors: every edge sees the values settled before it, so request and
   // result beats are taken in a race-free way
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_request({req_vel_front_left, req_vel_front_right, req_vel_back_left,
                          req_vel_back_right, req_ref_linear, req_ref_angular});
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response({rsp_drive_left, rsp_drive_right, rsp_speed_linear,
                            rsp_speed_angular, rsp_clamped});
   end

   // result side back-pressure; a hold-off request stalls for a long stretch
   // so that the block fills up and pushes back on its request channel
   always @(posedge clock) begin
      if (hold_requests != hold_seen) begin
         hold_seen <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // drivers
   // -------------------------------------------------------------------------
   task automatic set_idling(input idle_mode_type mode);
      sender_idle_pct = (mode == IDLE_SENDER)   ? 68 : (mode == IDLE_BOTH) ? 35 : 0;
      rsp_stall_pct   = (mode == IDLE_RECEIVER) ? 68 : (mode == IDLE_BOTH) ? 35 : 0;
   endtask

   // one request beat; valid stays up after acceptance unless the next beat idles
   task automatic send_request(input wheel_req_type r);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_vel_front_left  <= r.vel_front_left;
      req_vel_front_right <= r.vel_front_right;
      req_vel_back_left   <= r.vel_back_left;
      req_vel_back_right  <= r.vel_back_right;
      req_ref_linear      <= r.ref_linear;
      req_ref_angular     <= r.ref_angular;
      do @(posedge clock); while (req_stall);
   endtask

   // close the stream and wait for every predicted result to come back;
   // one edge first so that the monitor has noted the last accepted beat
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_drives.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
   endtask

   task automatic apply_settings(input logic [CFG_W-1:0] wd, tw, gpl, gdl, gpa, gda, lim);
      write_csr(REG_WHEEL_DIAMETER, wd);
      write_csr(REG_TRACK_WIDTH, tw);
      write_csr(REG_GAIN_P_LINEAR, gpl);
      write_csr(REG_GAIN_D_LINEAR, gdl);
      write_csr(REG_GAIN_P_ANGULAR, gpa);
      write_csr(REG_GAIN_D_ANGULAR, gda);
      write_csr(REG_DRIVE_LIMIT, lim);
      csr_valid <= 1'b0;
   endtask

   // write to the unused index; the shadow ignores it just as the block should
   task automatic write_unmapped(input logic [CFG_W-1:0] data);
      @(posedge clock);
      write_csr(REG_UNMAPPED, data);
      csr_valid <= 1'b0;
   endtask

   function automatic wheel_req_type beat(input logic [IN_W-1:0] fl, fr, bl, br, rl, ra);
      return {fl, fr, bl, br, rl, ra};
   endfunction

   function automatic logic [IN_W-1:0] spread(input int span);
      int v;
      v = int'($urandom_range(2 * span - 1)) - span;
      return IN_W'(v);
   endfunction

   function automatic logic [CFG_W-1:0] pick(input int lo, input int hi);
      return CFG_W'($urandom_range(hi, lo));
   endfunction

   // mostly plausible driving, some full-range noise and saturating references
   function automatic wheel_req_type random_request();
      wheel_req_type r;
      int            base;
      case ($urandom_range(3))
         0: r = wheel_req_type'({$urandom, $urandom, $urandom});
         1: r = beat(spread(1024), spread(1024), spread(1024), spread(1024),
                     spread(3072), spread(3072));
         2: begin
            // near-straight run: both sides close to a common wheel speed
            base = int'($urandom_range(16383)) - 8192;
            r = beat(IN_W'(base + int'($urandom_range(127)) - 64),
                     IN_W'(base + int'($urandom_range(127)) - 64),
                     IN_W'(base + int'($urandom_range(127)) - 64),
                     IN_W'(base + int'($urandom_range(127)) - 64),
                     spread(4096), spread(4096));
         end
         default: r = beat(spread(256), spread(256), spread(256), spread(256),
                           IN_W'($urandom), IN_W'($urandom));
      endcase
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // stimulus sequence
   // -------------------------------------------------------------------------
   initial begin
      int p;
      int n;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_idling(IDLE_NONE);

      // reset defaults: field extremes, reference clamp edges, sign flips
      send_request(beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      send_request(beat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      send_request(beat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
      send_request(beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd2560, 16'd2560));
      send_request(beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, -16'sd2560, -16'sd2560));
      send_request(beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd2561, 16'h7FFF));
      send_request(beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, -16'sd2561));
      send_request(beat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000));
      send_request(beat(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000));
      send_request(beat(16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'd1000, -16'sd1000));
      send_request(beat(16'h0100, 16'h0100, 16'h0100, 16'h0100, -16'sd1000, 16'd1000));
      drain_results();

      // zero track width counts as one lsb; largest wheel and limit
      apply_settings(16'hFFFF, 16'h0000, 16'd640, 16'd256, 16'd6400, 16'd3840, 16'h7FFF);
      send_request(beat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000));
      send_request(beat(16'h0003, 16'hFFFD, 16'h0001, 16'h0002, 16'd300, -16'sd300));
      drain_results();

      // zero drive limit: drives pinned at zero, clamped whenever they moved
      apply_settings(16'd64, 16'd256, 16'd640, 16'd0, 16'd6400, 16'd3840, 16'h0000);
      send_request(beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      send_request(beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd2560, 16'h0000));
      drain_results();

      // unity linear gain and no angular action: drive is half the reference,
      // so a reference of 2000 lands exactly on a limit of 1000
      apply_settings(16'd64, 16'd256, 16'd256, 16'd0, 16'd0, 16'd0, 16'd1000);
      write_unmapped(16'h1234);
      send_request(beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd2000, 16'h0000));
      send_request(beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, -16'sd2000, 16'h0000));
      send_request(beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd2002, 16'h0000));
      send_request(beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, -16'sd2002, 16'h0000));
      drain_results();

      // random phases, each with its own register set and idling pattern
      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: apply_settings(WHEEL_DIAMETER_RST, TRACK_WIDTH_RST, GAIN_P_LINEAR_RST,
                              GAIN_D_LINEAR_RST, GAIN_P_ANGULAR_RST, GAIN_D_ANGULAR_RST,
                              CFG_W'(DRIVE_LIMIT_RST));
            // everything at the top; the limit write also checks its masking
            1: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF);
            2: apply_settings(16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
            3: begin
               apply_settings(pick(16, 512), pick(64, 1024), pick(0, 8192), pick(0, 4096),
                              pick(0, 8192), pick(0, 4096), pick(0, 32767));
               write_unmapped(pick(0, 65535));
            end
            4: apply_settings(pick(1, 65535), 16'h0000, pick(0, 65535), pick(0, 65535),
                              pick(0, 65535), pick(0, 65535), pick(0, 65535));
            5: apply_settings(pick(1, 65535), pick(1, 65535), pick(0, 65535),
                              pick(0, 65535), pick(0, 65535), pick(0, 65535),
                              pick(0, 65535));
            6: apply_settings(pick(32, 128), pick(128, 512), pick(128, 1024), pick(0, 512),
                              pick(512, 8192), pick(0, 4096), pick(0, 2048));
            default: apply_settings(pick(16, 512), pick(1, 2048), pick(0, 8192),
                                    pick(0, 8192), pick(0, 8192), pick(0, 8192),
                                    pick(0, 32767));
         endcase
         set_idling(idle_mode_type'(p % 4));
         // long result hold-off while requests keep coming
         if (p == 1 || p == 5) hold_requests = hold_requests + 1;
         for (n = 0; n < ITEMS_PER_PHASE; n++) send_request(random_request());
         drain_results();
      end

      // let any stray result beat show up before the verdict
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_drives.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
